// ----- hw/rtl/aqm_pkg.sv -----
// shared constants, codes and types of the audio quality monitor
package aqm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int CH_W          = 4;
  localparam int CH_MAX        = 8;
  localparam int REM_W         = 3;
  localparam int THR_W         = 16;
  localparam int LEVEL_W       = 15;
  localparam int LSQ_W         = 2 * LEVEL_W;
  localparam int SQ_W          = 31;
  localparam int MINF_W        = 16;
  localparam int MAX_CHUNK_DEF = 8192;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES = 2'd3;

  localparam logic [CH_W-1:0]    CHANNELS_RST   = 4'd2;
  localparam logic [THR_W-1:0]   THRESHOLD_RST  = 16'd8000;
  localparam logic [LEVEL_W-1:0] LEVEL_RST      = 15'd104;
  localparam logic [MINF_W-1:0]  MIN_FRAMES_RST = 16'd240;

  typedef struct packed {
    logic [63:0] total_energy;
    logic [31:0] sample_count;
    logic [14:0] peak_level;
    logic [31:0] click_count;
  } aqm_snap_t;

  typedef struct packed {
    logic [63:0] total_energy;
    logic [31:0] sample_count;
    logic [14:0] peak_level;
    logic [31:0] click_count;
    logic [31:0] dropout_count;
    logic        dropout_active;
    logic        chunk_quiet;
  } aqm_result_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic inc;
    logic finish;
  } aqm_div_ctl_t;

endpackage

// ----- hw/rtl/aqm_if.sv -----
// sample and result stream interfaces of the audio quality monitor
interface aqm_in_if import aqm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       chunk_first;
  logic                       chunk_last;
  logic                       clear_stats;

  modport source (output valid, sample, chunk_first, chunk_last, clear_stats, input ready);
  modport sink (input valid, sample, chunk_first, chunk_last, clear_stats, output ready);
endinterface

interface aqm_out_if import aqm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] total_energy;
  logic [31:0] sample_count;
  logic [14:0] peak_level;
  logic [31:0] click_count;
  logic [31:0] dropout_count;
  logic        dropout_active;
  logic        chunk_quiet;

  modport source (output valid, total_energy, sample_count, peak_level, click_count,
                  dropout_count, dropout_active, chunk_quiet, input ready);
  modport sink (input valid, total_energy, sample_count, peak_level, click_count,
                dropout_count, dropout_active, chunk_quiet, output ready);
endinterface

// ----- hw/rtl/aqm_frame_div.sv -----
// whole-frame count of the current chunk for every channel count
module aqm_frame_div import aqm_pkg::*; #(
  parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  aqm_div_ctl_t                               ctl,
  input  logic [CH_W-1:0]                            ch,
  output logic [$clog2(MAX_CHUNK_SAMPLES+1)-1:0]     frames
);

  localparam int CW = $clog2(MAX_CHUNK_SAMPLES + 1);

  logic [CW-1:0]    q_r   [CH_MAX];
  logic [CW-1:0]    q_nxt [CH_MAX];
  logic [CW-1:0]    qn    [CH_MAX];
  logic [REM_W-1:0] r_r   [CH_MAX];
  logic [REM_W-1:0] r_nxt [CH_MAX];
  logic [REM_W-1:0] rn    [CH_MAX];
  logic [CH_W-1:0]  ch_m1;

  always_comb begin
    for (int i = 0; i < CH_MAX; i++) begin
      qn[i] = ctl.restart ? '0 : q_r[i];
      rn[i] = ctl.restart ? '0 : r_r[i];
      if (ctl.inc) begin
        if (rn[i] == REM_W'(i)) begin
          qn[i] = qn[i] + 1'b1;
          rn[i] = '0;
        end else begin
          rn[i] = rn[i] + 1'b1;
        end
      end
      q_nxt[i] = ctl.finish ? '0 : qn[i];
      r_nxt[i] = ctl.finish ? '0 : rn[i];
    end
  end

  assign ch_m1  = ch - 4'd1;
  assign frames = qn[ch_m1[REM_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH_MAX; i++) begin
        q_r[i] <= '0;
        r_r[i] <= '0;
      end
    end else if (ctl.step) begin
      for (int i = 0; i < CH_MAX; i++) begin
        q_r[i] <= q_nxt[i];
        r_r[i] <= r_nxt[i];
      end
    end
  end

endmodule

// ----- hw/rtl/audio_quality_monitor.sv -----
// audio quality monitor: running energy, peak, click and dropout statistics
// one sample transfer per cycle unless a waiting result stalls the pipe
// the result of a chunk is presented from the result register, behind the statistics stage
// stages: input register, squaring, statistics update, dropout update into the result register
// a waiting result stalls the pipe once the next chunk-end sample reaches the last stage
// reset is synchronous and active low: statistics cleared, configuration back to defaults
module audio_quality_monitor import aqm_pkg::*; #(
  parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  aqm_in_if.sink                in_ch,
  aqm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int CEW = CW + LSQ_W;

  // configuration
  logic [CH_W-1:0]    ch_r;
  logic [THR_W-1:0]   thr_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [MINF_W-1:0]  minf_r;
  logic [LSQ_W-1:0]   lsq_r;
  logic [CH_W-1:0]    ch_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= CHANNELS_RST;
      thr_r  <= THRESHOLD_RST;
      lvl_r  <= LEVEL_RST;
      minf_r <= MIN_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNELS:   ch_r   <= cfg_wdata[CH_W-1:0];
        CFG_THRESHOLD:  thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_LEVEL:      lvl_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_MIN_FRAMES: minf_r <= cfg_wdata[MINF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lsq_r <= LSQ_W'(lvl_r) * LSQ_W'(lvl_r);
  end

  assign ch_eff = (ch_r == '0) ? 4'd1 :
                  (ch_r > CH_W'(CH_MAX)) ? CH_W'(CH_MAX) : ch_r;

  // pipeline flow
  logic v1_r, v2_r, v3_r, out_v_r;
  logic go1, en2, a_go, en3, b_go, in_rdy;

  logic s1_last_r, s2_last_r, s3_last_r;

  assign b_go   = v3_r && (!s3_last_r || !out_v_r || out_ch.ready);
  assign en3    = !v3_r || b_go;
  assign a_go   = v2_r && en3;
  assign en2    = !v2_r || a_go;
  assign go1    = v1_r && en2;
  assign in_rdy = !v1_r || go1;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_rdy) v1_r <= in_ch.valid;
      if (en2)    v2_r <= v1_r;
      if (en3)    v3_r <= v2_r;
    end
  end

  // input register
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_first_r, s1_clr_r;

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      s1_sample_r <= in_ch.sample;
      s1_first_r  <= in_ch.chunk_first;
      s1_last_r   <= in_ch.chunk_last;
      s1_clr_r    <= in_ch.clear_stats;
    end
  end

  // magnitude and square
  logic [SAMPLE_W:0] s1_ext, s1_mag;
  logic [33:0]       s1_sq_full;

  assign s1_ext     = {s1_sample_r[SAMPLE_W-1], s1_sample_r};
  assign s1_mag     = s1_sample_r[SAMPLE_W-1] ? (~s1_ext + 1'b1) : s1_ext;
  assign s1_sq_full = 34'(s1_mag) * 34'(s1_mag);

  logic signed [SAMPLE_W-1:0] s2_sample_r;
  logic [SQ_W-1:0]            s2_sq_r;
  logic [14:0]                s2_mag_r;
  logic                       s2_first_r, s2_clr_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sample_r <= s1_sample_r;
      s2_sq_r     <= s1_sq_full[SQ_W-1:0];
      s2_mag_r    <= s1_mag[15] ? 15'h7fff : s1_mag[14:0];
      s2_first_r  <= s1_first_r;
      s2_last_r   <= s1_last_r;
      s2_clr_r    <= s1_clr_r;
    end
  end

  // statistics and chunk state
  logic [63:0]                energy_r, energy_nxt, e0;
  logic [31:0]                samples_r, samples_nxt, st0;
  logic [14:0]                peak_r, peak_nxt, p0;
  logic [31:0]                clicks_r, clicks_nxt, c0;
  logic signed [SAMPLE_W-1:0] prev_end_r, prev_end_nxt;
  logic signed [SAMPLE_W-1:0] fstart_r, fstart_nxt;
  logic [REM_W-1:0]           pos_r, pos_nxt, pos0, pos1;
  logic [CW-1:0]              cnt_r, cnt_nxt, cnt0, cnt1;
  logic [CEW-1:0]             ce_r, ce_nxt, ce0, ce1;
  logic [64:0]                esum;
  logic [SAMPLE_W:0]          diff, adiff;
  logic                       click, chunk_inc, end_ok;
  logic [CW-1:0]              frames;
  aqm_div_ctl_t               div_ctl;

  always_comb begin
    e0   = s2_clr_r ? '0 : energy_r;
    st0  = s2_clr_r ? '0 : samples_r;
    p0   = s2_clr_r ? '0 : peak_r;
    c0   = s2_clr_r ? '0 : clicks_r;
    esum = {1'b0, e0} + 65'(s2_sq_r);
    energy_nxt  = esum[64] ? '1 : esum[63:0];
    samples_nxt = (st0 == '1) ? st0 : st0 + 1'b1;
    peak_nxt    = (s2_mag_r > p0) ? s2_mag_r : p0;

    diff  = {s2_sample_r[SAMPLE_W-1], s2_sample_r} - {prev_end_r[SAMPLE_W-1], prev_end_r};
    adiff = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    click = s2_first_r && (adiff > {1'b0, thr_r}) && (prev_end_r != '0);
    clicks_nxt = click ? c0 + 1'b1 : c0;

    pos0 = s2_first_r ? '0 : pos_r;
    pos1 = ({1'b0, pos0} >= ch_eff) ? '0 : pos0;
    fstart_nxt = (pos1 == '0) ? s2_sample_r : fstart_r;
    pos_nxt = ({1'b0, pos1} + 4'd1 >= ch_eff) ? '0 : pos1 + 1'b1;

    cnt0 = s2_first_r ? '0 : cnt_r;
    ce0  = s2_first_r ? '0 : ce_r;
    chunk_inc = cnt0 < CW'(MAX_CHUNK_SAMPLES);
    cnt1 = chunk_inc ? cnt0 + 1'b1 : cnt0;
    ce1  = chunk_inc ? ce0 + CEW'(s2_sq_r) : ce0;

    end_ok = {{(32-CW){1'b0}}, cnt1} >= {{(32-CH_W){1'b0}}, ch_eff};
    prev_end_nxt = (s2_last_r && end_ok) ? fstart_nxt : prev_end_r;

    cnt_nxt = s2_last_r ? '0 : cnt1;
    ce_nxt  = s2_last_r ? '0 : ce1;
    if (s2_last_r) pos_nxt = '0;
  end

  assign div_ctl.step    = a_go;
  assign div_ctl.restart = s2_first_r;
  assign div_ctl.inc     = chunk_inc;
  assign div_ctl.finish  = s2_last_r;

  aqm_frame_div #(
    .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
  ) u_frame_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (div_ctl),
    .ch     (ch_eff),
    .frames (frames)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r   <= '0;
      samples_r  <= '0;
      peak_r     <= '0;
      clicks_r   <= '0;
      prev_end_r <= '0;
      fstart_r   <= '0;
      pos_r      <= '0;
      cnt_r      <= '0;
      ce_r       <= '0;
    end else if (a_go) begin
      energy_r   <= energy_nxt;
      samples_r  <= samples_nxt;
      peak_r     <= peak_nxt;
      clicks_r   <= clicks_nxt;
      prev_end_r <= prev_end_nxt;
      fstart_r   <= fstart_nxt;
      pos_r      <= pos_nxt;
      cnt_r      <= cnt_nxt;
      ce_r       <= ce_nxt;
    end
  end

  aqm_snap_t      s3_snap_r;
  logic [CEW-1:0] s3_ce_r;
  logic [CW-1:0]  s3_frames_r, s3_cnt_r;
  logic           s3_clr_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_snap_r.total_energy <= energy_nxt;
      s3_snap_r.sample_count <= samples_nxt;
      s3_snap_r.peak_level   <= peak_nxt;
      s3_snap_r.click_count  <= clicks_nxt;
      s3_ce_r     <= ce1;
      s3_cnt_r    <= cnt1;
      s3_frames_r <= frames;
      s3_last_r   <= s2_last_r;
      s3_clr_r    <= s2_clr_r;
    end
  end

  // quiet run and dropout state
  logic [31:0]    qf_r, qf_nxt, qf0, qf_add;
  logic [31:0]    drops_r, drops_nxt, dc0;
  logic           indrop_r, indrop_nxt, ind0, quiet;
  logic [32:0]    qsum;
  logic [CEW-1:0] s3_lim;
  aqm_result_t    out_r;

  always_comb begin
    qf0    = s3_clr_r ? '0 : qf_r;
    ind0   = s3_clr_r ? 1'b0 : indrop_r;
    dc0    = s3_clr_r ? '0 : drops_r;
    s3_lim = CEW'(lsq_r) * CEW'(s3_cnt_r);
    quiet  = s3_ce_r < s3_lim;
    qsum   = {1'b0, qf0} + 33'(s3_frames_r);
    qf_add = qsum[32] ? '1 : qsum[31:0];
    qf_nxt     = qf0;
    indrop_nxt = ind0;
    drops_nxt  = dc0;
    if (s3_last_r) begin
      if (quiet) begin
        qf_nxt = qf_add;
        if (!ind0 && (qf_add > {16'd0, minf_r})) begin
          indrop_nxt = 1'b1;
          drops_nxt  = dc0 + 1'b1;
        end
      end else begin
        qf_nxt     = '0;
        indrop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qf_r     <= '0;
      indrop_r <= 1'b0;
      drops_r  <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (b_go) begin
        qf_r     <= qf_nxt;
        indrop_r <= indrop_nxt;
        drops_r  <= drops_nxt;
      end
      if (b_go && s3_last_r) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (b_go && s3_last_r) begin
      out_r.total_energy   <= s3_snap_r.total_energy;
      out_r.sample_count   <= s3_snap_r.sample_count;
      out_r.peak_level     <= s3_snap_r.peak_level;
      out_r.click_count    <= s3_snap_r.click_count;
      out_r.dropout_count  <= drops_nxt;
      out_r.dropout_active <= indrop_nxt;
      out_r.chunk_quiet    <= quiet;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.total_energy   = out_r.total_energy;
  assign out_ch.sample_count   = out_r.sample_count;
  assign out_ch.peak_level     = out_r.peak_level;
  assign out_ch.click_count    = out_r.click_count;
  assign out_ch.dropout_count  = out_r.dropout_count;
  assign out_ch.dropout_active = out_r.dropout_active;
  assign out_ch.chunk_quiet    = out_r.chunk_quiet;

endmodule
